[rtl/tpd_pkg.sv]
package tpd_pkg;

    // One input item: a command and the stream byte that goes with it.
    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } rx_item_t;

    // One result item.
    typedef struct packed {
        logic [31:0] height_bits;
        logic [31:0] distance_bits;
        logic        point_valid;
        logic        packet_end;
        logic        aborted;
    } res_item_t;

    // Status of the result queue as seen by the back part and the rx stall logic.
    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    // Parse phase of the deframer.
    typedef enum logic [2:0] {
        PH_HUNT    = 3'b001,
        PH_HEADER  = 3'b010,
        PH_PAYLOAD = 3'b100
    } phase_t;

    localparam logic CMD_DATA       = 1'b0;
    localparam logic CMD_DISCONNECT = 1'b1;

    localparam logic REG_MAGIC = 1'b0;
    localparam logic REG_TYPE  = 1'b1;

    localparam logic [31:0] MAGIC_RESET = 32'h536F_7447;
    localparam logic [31:0] TYPE_RESET  = 32'd456;

    localparam logic [3:0] HEADER_AFTER_MAGIC = 4'd4;
    localparam logic [3:0] HEADER_LAST        = 4'd15;
    localparam logic [2:0] RECORD_LAST        = 3'd7;
    localparam logic [1:0] HUNT_FULL          = 2'd3;

    localparam logic [31:0] NEG_ZERO_BITS = 32'h8000_0000;
    localparam logic [30:0] POS_INF_MAG   = 31'h7F80_0000;

endpackage

[rtl/tpd_front.sv]
module tpd_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [31:0]        magic_word,
    input  logic [31:0]        expected_type,
    input  logic               accept,
    input  tpd_pkg::rx_item_t  item,
    output logic               res_push,
    output tpd_pkg::res_item_t res
);
    import tpd_pkg::*;

    phase_t      phase_reg,        phase_next;
    logic [23:0] hunt_window_reg,  hunt_window_next;
    logic [1:0]  hunt_fill_reg,    hunt_fill_next;
    logic [3:0]  header_index_reg, header_index_next;
    logic [31:0] type_field_reg,   type_field_next;
    logic [30:0] points_left_reg,  points_left_next;
    logic [2:0]  record_index_reg, record_index_next;
    logic [55:0] record_bytes_reg, record_bytes_next;

    logic [30:0] count;
    logic [30:0] points_dec;
    logic [31:0] h_word;
    logic [31:0] d_word;
    logic        h_ok;
    logic        last;
    logic        clear_all;

    assign count      = {item.data_byte[6:0], points_left_reg[23:0]};
    assign points_dec = points_left_reg - 31'd1;
    assign last       = (points_dec == '0);
    assign h_word     = record_bytes_reg[31:0];
    assign d_word     = {item.data_byte, record_bytes_reg[55:32]};
    // Height >= 0 tested on the bits: negative zero passes, every NaN fails.
    assign h_ok       = (h_word == NEG_ZERO_BITS) ||
                        (!h_word[31] && (h_word[30:0] <= POS_INF_MAG));

    always_comb
    begin
        phase_next        = phase_reg;
        hunt_window_next  = hunt_window_reg;
        hunt_fill_next    = hunt_fill_reg;
        header_index_next = header_index_reg;
        type_field_next   = type_field_reg;
        points_left_next  = points_left_reg;
        record_index_next = record_index_reg;
        record_bytes_next = record_bytes_reg;
        clear_all         = 1'b0;
        res_push          = 1'b0;
        res               = '0;

        if (accept)
        begin
            if (item.command == CMD_DISCONNECT)
            begin
                clear_all = 1'b1;
                if (phase_reg == PH_PAYLOAD)
                begin
                    res_push    = 1'b1;
                    res.aborted = 1'b1;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        header_index_next = header_index_reg + 4'd1;
                        if (header_index_reg[3:2] == 2'b01)
                        begin
                            type_field_next[{header_index_reg[1:0], 3'b000} +: 8] =
                                item.data_byte;
                        end
                        else if (header_index_reg == HEADER_LAST)
                        begin
                            if (type_field_reg != expected_type)
                            begin
                                clear_all = 1'b1;
                            end
                            else if (item.data_byte[7] || (count == '0))
                            begin
                                // Empty or negative count: close the packet straight away.
                                clear_all      = 1'b1;
                                res_push       = 1'b1;
                                res.packet_end = 1'b1;
                            end
                            else
                            begin
                                phase_next        = PH_PAYLOAD;
                                points_left_next  = count;
                                header_index_next = '0;
                                record_index_next = '0;
                                record_bytes_next = '0;
                            end
                        end
                        else if (header_index_reg[3:2] == 2'b11)
                        begin
                            points_left_next[{header_index_reg[1:0], 3'b000} +: 8] =
                                item.data_byte;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        if (record_index_reg != RECORD_LAST)
                        begin
                            record_bytes_next[{record_index_reg, 3'b000} +: 8] =
                                item.data_byte;
                            record_index_next = record_index_reg + 3'd1;
                        end
                        else
                        begin
                            points_left_next  = points_dec;
                            record_index_next = '0;
                            record_bytes_next = '0;
                            clear_all         = last;
                            if (h_ok)
                            begin
                                res_push          = 1'b1;
                                res.height_bits   = h_word;
                                res.distance_bits = d_word;
                                res.point_valid   = 1'b1;
                                res.packet_end    = last;
                            end
                            else if (last)
                            begin
                                res_push       = 1'b1;
                                res.packet_end = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        if ((hunt_fill_reg == HUNT_FULL) &&
                            ({item.data_byte, hunt_window_reg} == magic_word))
                        begin
                            phase_next        = PH_HEADER;
                            hunt_window_next  = '0;
                            hunt_fill_next    = '0;
                            header_index_next = HEADER_AFTER_MAGIC;
                            type_field_next   = '0;
                            points_left_next  = '0;
                        end
                        else
                        begin
                            phase_next       = PH_HUNT;
                            hunt_window_next = {item.data_byte, hunt_window_reg[23:8]};
                            if (hunt_fill_reg != HUNT_FULL)
                            begin
                                hunt_fill_next = hunt_fill_reg + 2'd1;
                            end
                        end
                    end
                endcase
            end
        end

        if (clear_all)
        begin
            phase_next        = PH_HUNT;
            hunt_window_next  = '0;
            hunt_fill_next    = '0;
            header_index_next = '0;
            type_field_next   = '0;
            points_left_next  = '0;
            record_index_next = '0;
            record_bytes_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HUNT;
            hunt_window_reg  <= '0;
            hunt_fill_reg    <= '0;
            header_index_reg <= '0;
            type_field_reg   <= '0;
            points_left_reg  <= '0;
            record_index_reg <= '0;
            record_bytes_reg <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            hunt_window_reg  <= hunt_window_next;
            hunt_fill_reg    <= hunt_fill_next;
            header_index_reg <= header_index_next;
            type_field_reg   <= type_field_next;
            points_left_reg  <= points_left_next;
            record_index_reg <= record_index_next;
            record_bytes_reg <= record_bytes_next;
        end
    end

    // A result never carries a point and an abort at once.
    a_point_not_aborted: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !(res.point_valid && res.aborted))
        else $error("result carries both a point and an abort");

    // A disconnect always leaves the parser hunting.
    a_disconnect_hunts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.command == CMD_DISCONNECT)) |=> (phase_reg == PH_HUNT))
        else $error("parser not hunting after disconnect");

endmodule

[rtl/tpd_queue.sv]
module tpd_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  tpd_pkg::res_item_t din,
    input  logic               pop,
    output tpd_pkg::res_item_t dout,
    output tpd_pkg::q_status_t status
);
    import tpd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    res_item_t     slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_FULL);
    assign dout         = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!status.full || pop))
        else $error("result queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("result queue read while empty");

endmodule

[rtl/tpd_back.sv]
module tpd_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  tpd_pkg::q_status_t q_status,
    input  tpd_pkg::res_item_t q_data,
    output logic               pop,
    output logic               res_valid,
    input  logic               res_stall,
    output tpd_pkg::res_item_t res_item
);
    import tpd_pkg::*;

    logic      valid_reg, valid_next;
    res_item_t item_reg;

    // The output register takes a new item when empty or when its item leaves.
    assign pop        = !q_status.empty && (!valid_reg || !res_stall);
    assign valid_next = pop || (valid_reg && res_stall);
    assign res_valid  = valid_reg;
    assign res_item   = item_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= q_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

endmodule

[rtl/trajectory_packet_deframer_core.sv]
// Channel  | Handshake                 | Payload
// rx       | rx_valid / rx_stall       | rx_item  (command, data_byte)
// res      | res_valid / res_stall     | res_item (height, distance, flags)
// config   | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// One input item is taken every cycle while the result queue has room.
// A result passes through the result queue and the output register before it reaches res_valid.
// rx_stall is high only while the result queue (QUEUE_DEPTH entries) is full.
// Reset is asynchronous and active low; it restores the registers to their
// reset values and sends the parser back to hunting for the magic word.
module trajectory_packet_deframer_core
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               rx_valid,
    output logic               rx_stall,
    input  tpd_pkg::rx_item_t  rx_item,

    output logic               res_valid,
    input  logic               res_stall,
    output tpd_pkg::res_item_t res_item,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import tpd_pkg::*;

    logic [31:0] magic_word_reg;
    logic [31:0] expected_type_reg;
    logic        cfg_write;
    logic        rx_accept;
    logic        res_push;
    logic        q_pop;
    res_item_t   front_res;
    res_item_t   q_data;
    q_status_t   q_status;

    // The configuration registers sit at byte addresses 0 and 4; the lowest
    // two address bits are not decoded.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_TYPE) ? expected_type_reg : magic_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_word_reg    <= MAGIC_RESET;
            expected_type_reg <= TYPE_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_MAGIC)
            begin
                magic_word_reg <= pwdata;
            end
            else
            begin
                expected_type_reg <= pwdata;
            end
        end
    end

    // Items are taken only while the queue is not full, so that it can hold the result they may cause.
    assign rx_stall  = q_status.full;
    assign rx_accept = rx_valid && !rx_stall;

    // Front part: parses the byte stream and classifies each item.
    tpd_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .magic_word    (magic_word_reg),
        .expected_type (expected_type_reg),
        .accept        (rx_accept),
        .item          (rx_item),
        .res_push      (res_push),
        .res           (front_res)
    );

    // Short queue that lets the parser run on while the output is stalled.
    tpd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (res_push),
        .din    (front_res),
        .pop    (q_pop),
        .dout   (q_data),
        .status (q_status)
    );

    // Back part: output register towards the result channel.
    tpd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .q_data    (q_data),
        .pop       (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

endmodule

[sim/deframe_point_checker.sv]
module deframe_point_checker
    import tpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        rx_valid,
    input  logic        rx_stall,
    input  rx_item_t    rx_item,

    input  logic        res_valid,
    input  logic        res_stall,
    input  res_item_t   res_item,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,

    output int          mismatches,
    output int          outstanding
);

    // Register copies, as last written over the configuration port.
    logic [31:0] magic_reg;
    logic [31:0] type_reg;

    // Parser state of the predicted deframer.
    phase_t      phase;
    logic [23:0] hunt_window;
    logic [1:0]  hunt_fill;
    logic [3:0]  header_index;
    logic [31:0] type_field;
    logic [30:0] points_left;
    logic [2:0]  record_index;
    logic [55:0] record_bytes;

    res_item_t   points_due[$];
    res_item_t   want;
    res_item_t   predicted;
    bit          emits;
    logic [31:0] reg_value;
    int          fail_total;

    task automatic report_fault(input string what);
        fail_total++;
        if (fail_total <= 10)
        begin
            $display("%0t: %s", $time, what);
        end
    endtask

    task automatic restart_hunt();
        phase        = PH_HUNT;
        hunt_window  = '0;
        hunt_fill    = '0;
        header_index = '0;
        type_field   = '0;
        points_left  = '0;
        record_index = '0;
        record_bytes = '0;
    endtask

    // Advances the parser by one item and says whether a point record,
    // a packet end or an abort comes out of it.
    task automatic deframe_byte(input rx_item_t it, output bit emit, output res_item_t pt);
        logic [30:0] count;
        logic [31:0] h;
        logic [31:0] d;
        bit          height_ok;
        bit          last_rec;
        emit = 1'b0;
        pt   = '0;
        if (it.command == CMD_DISCONNECT)
        begin
            emit       = (phase == PH_PAYLOAD);
            pt.aborted = emit;
            restart_hunt();
        end
        else if (phase == PH_HEADER)
        begin
            if (header_index >= 4 && header_index < 8)
            begin
                type_field[8 * (header_index - 4) +: 8] = it.data_byte;
            end
            else if (header_index >= 12 && header_index < HEADER_LAST)
            begin
                points_left[8 * (header_index - 12) +: 8] = it.data_byte;
            end
            if (header_index == HEADER_LAST)
            begin
                count = {it.data_byte[6:0], points_left[23:0]};
                if (type_field != type_reg)
                begin
                    restart_hunt();
                end
                else if (it.data_byte[7] || count == '0)
                begin
                    restart_hunt();
                    emit          = 1'b1;
                    pt.packet_end = 1'b1;
                end
                else
                begin
                    phase        = PH_PAYLOAD;
                    points_left  = count;
                    header_index = '0;
                    record_index = '0;
                    record_bytes = '0;
                end
            end
            else
            begin
                header_index = header_index + 1'b1;
            end
        end
        else if (phase == PH_PAYLOAD)
        begin
            if (record_index != RECORD_LAST)
            begin
                record_bytes[8 * record_index +: 8] = it.data_byte;
                record_index = record_index + 1'b1;
            end
            else
            begin
                h = record_bytes[31:0];
                d = {it.data_byte, record_bytes[55:32]};
                // Negative zero passes; any other set sign or a NaN fails.
                height_ok    = (h == NEG_ZERO_BITS) || (!h[31] && h[30:0] <= POS_INF_MAG);
                points_left  = points_left - 1'b1;
                last_rec     = (points_left == '0);
                record_index = '0;
                record_bytes = '0;
                if (last_rec)
                begin
                    restart_hunt();
                end
                if (height_ok)
                begin
                    emit             = 1'b1;
                    pt.height_bits   = h;
                    pt.distance_bits = d;
                    pt.point_valid   = 1'b1;
                    pt.packet_end    = last_rec;
                end
                else if (last_rec)
                begin
                    emit          = 1'b1;
                    pt.packet_end = 1'b1;
                end
            end
        end
        else
        begin
            if (hunt_fill == HUNT_FULL && {it.data_byte, hunt_window} == magic_reg)
            begin
                restart_hunt();
                phase        = PH_HEADER;
                header_index = HEADER_AFTER_MAGIC;
            end
            else
            begin
                phase       = PH_HUNT;
                hunt_window = {it.data_byte, hunt_window[23:8]};
                if (hunt_fill != HUNT_FULL)
                begin
                    hunt_fill = hunt_fill + 1'b1;
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg = MAGIC_RESET;
            type_reg  = TYPE_RESET;
            restart_hunt();
            points_due.delete();
            fail_total  = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (points_due.size() == 0)
                begin
                    report_fault($sformatf("unexpected result h=%h d=%h v=%b e=%b a=%b",
                        res_item.height_bits, res_item.distance_bits,
                        res_item.point_valid, res_item.packet_end, res_item.aborted));
                end
                else
                begin
                    want = points_due.pop_front();
                    if (res_item.height_bits !== want.height_bits
                        || res_item.distance_bits !== want.distance_bits
                        || res_item.point_valid !== want.point_valid
                        || res_item.packet_end !== want.packet_end
                        || res_item.aborted !== want.aborted)
                    begin
                        report_fault($sformatf(
                            {"result mismatch: expected h=%h d=%h v=%b e=%b a=%b, ",
                             "got h=%h d=%h v=%b e=%b a=%b"},
                            want.height_bits, want.distance_bits, want.point_valid,
                            want.packet_end, want.aborted,
                            res_item.height_bits, res_item.distance_bits,
                            res_item.point_valid, res_item.packet_end, res_item.aborted));
                    end
                end
            end

            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr == {REG_MAGIC, 2'b00})
                    begin
                        magic_reg = pwdata;
                    end
                    else if (paddr == {REG_TYPE, 2'b00})
                    begin
                        type_reg = pwdata;
                    end
                end
                else
                begin
                    reg_value = (paddr == {REG_TYPE, 2'b00}) ? type_reg : magic_reg;
                    if (prdata !== reg_value)
                    begin
                        report_fault($sformatf("register read at %0d: expected %h, got %h",
                            paddr, reg_value, prdata));
                    end
                end
            end

            if (rx_valid && !rx_stall)
            begin
                deframe_byte(rx_item, emits, predicted);
                if (emits)
                begin
                    points_due.push_back(predicted);
                end
            end

            mismatches  <= fail_total;
            outstanding <= points_due.size();
        end
    end

endmodule

[sim/tb_trajectory_packet_deframer_core.sv]
module tb_trajectory_packet_deframer_core;
    import tpd_pkg::*;

    // Every input of the block starts at a known value, with reset held.
    logic        clk;
    logic        rst_n     = 1'b0;
    logic        rx_valid  = 1'b0;
    rx_item_t    rx_item   = '0;
    logic        res_stall = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;

    logic        rx_stall;
    logic        res_valid;
    res_item_t   res_item;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          outstanding;

    // The stimulus keeps its own note of the register values so that it can
    // build packets which the parser will actually accept.
    logic [31:0] magic_now = MAGIC_RESET;
    logic [31:0] type_now  = TYPE_RESET;

    // Idling switches for the sending and the receiving side. They are
    // flipped now and then so that runs of back-to-back traffic also occur.
    bit          send_idle = 1'b1;
    bit          take_idle = 1'b1;
    int          items_sent = 0;

    trajectory_packet_deframer_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_stall  (rx_stall),
        .rx_item   (rx_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    deframe_point_checker point_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_valid    (rx_valid),
        .rx_stall    (rx_stall),
        .rx_item     (rx_item),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res_item    (res_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .mismatches  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hands one item to the block. It is called at a rising edge and returns
    // at the edge where the item was taken, so that the next call can keep
    // valid high without lowering it in between.
    task send_item(input logic cmd, input logic [7:0] data);
        int gap;
        gap = send_idle ? $urandom_range(0, 19) : 0;
        if (gap != 0)
        begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_valid          <= 1'b1;
        rx_item.command   <= cmd;
        rx_item.data_byte <= data;
        do @(posedge clk); while (rx_stall);
        items_sent++;
    endtask

    // Words on the stream are little-endian: the low byte goes first.
    task send_word(input logic [31:0] word);
        for (int i = 0; i < 4; i++)
        begin
            send_item(CMD_DATA, word[8 * i +: 8]);
        end
    endtask

    // One packet with random content. Most packets are well formed so that the
    // parser spends its time in the header and payload phases; the rest carry
    // a wrong type, an empty or negative count, or are cut off by a disconnect.
    task send_packet();
        int          kind;
        int          n_rec;
        logic [31:0] typ;
        logic [31:0] count;
        logic [31:0] height;
        bit          cut;
        if ($urandom_range(0, 3) == 0)
        begin
            send_idle = ($urandom_range(0, 3) != 0);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            take_idle = ($urandom_range(0, 3) != 0);
        end

        // A little line noise ahead of the magic word, and now and then a
        // disconnect while the parser is only hunting.
        repeat ($urandom_range(0, 3)) send_item(CMD_DATA, 8'($urandom));
        if ($urandom_range(0, 15) == 0)
        begin
            send_item(CMD_DISCONNECT, 8'($urandom));
        end

        kind = $urandom_range(0, 19);
        typ  = (kind < 2) ? (type_now ^ (32'd1 << $urandom_range(0, 31))) : type_now;
        send_word(magic_now);
        send_word(typ);
        if (kind == 2)
        begin
            // Disconnect half way through the header: no item comes out.
            send_item(CMD_DISCONNECT, 8'($urandom));
            return;
        end
        send_word($urandom);
        case (kind)
            3:
            begin
                count = '0;
            end
            4:
            begin
                count = {1'b1, 31'($urandom)};
            end
            5:
            begin
                count = {1'b0, 31'($urandom)};
            end
            6:
            begin
                count = $urandom_range(5, 9);
            end
            default:
            begin
                count = $urandom_range(1, 4);
            end
        endcase
        send_word(count);
        if (typ != type_now || count[31] || count == '0)
        begin
            return;
        end

        // A huge count is always cut short, and so is one packet in ten.
        cut   = (kind == 5) || ($urandom_range(0, 9) == 0);
        n_rec = (kind == 5) ? $urandom_range(0, 3)
              : (cut ? $urandom_range(0, count - 1) : count);
        for (int k = 0; k < n_rec; k++)
        begin
            // Heights lean towards the edges of the sign test.
            case ($urandom_range(0, 9))
                0:
                begin
                    height = '0;
                end
                1:
                begin
                    height = NEG_ZERO_BITS;
                end
                2:
                begin
                    height = {1'b0, POS_INF_MAG};
                end
                3:
                begin
                    height = {1'b1, POS_INF_MAG};
                end
                4:
                begin
                    height = {1'b0, POS_INF_MAG} | $urandom_range(1, 32'h007F_FFFF);
                end
                5:
                begin
                    height = {1'b1, POS_INF_MAG} | $urandom_range(1, 32'h007F_FFFF);
                end
                6:
                begin
                    height = {1'b0, POS_INF_MAG} - 1'b1;
                end
                7:
                begin
                    height = NEG_ZERO_BITS | 32'd1;
                end
                default:
                begin
                    height = $urandom;
                end
            endcase
            send_word(height);
            send_word($urandom);
        end
        if (cut)
        begin
            repeat ($urandom_range(0, 7)) send_item(CMD_DATA, 8'($urandom));
            send_item(CMD_DISCONNECT, 8'($urandom));
        end
    endtask

    // One configuration transfer: a setup phase, then the access phase,
    // which lasts until pready is seen.
    task apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Stops sending and waits until every predicted item has been taken.
    task drain_results();
        rx_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // The receiving side: for every item it draws a stall time, holds stall
    // for that long, then takes whatever comes next.
    initial
    begin : result_taker
        int hold;
        @(posedge rst_n);
        forever
        begin
            hold = take_idle ? $urandom_range(0, 19) : 0;
            if (hold != 0)
            begin
                res_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            res_stall <= 1'b0;
            do @(posedge clk); while (!res_valid);
        end
    end

    initial
    begin : stimulus
        logic [31:0] m;
        logic [31:0] t;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Both registers should read back their reset values.
        apb_access(1'b0, {REG_MAGIC, 2'b00}, '0);
        apb_access(1'b0, {REG_TYPE, 2'b00}, '0);

        // Directed opening: a disconnect while hunting, then a one-point
        // packet under the reset settings whose height is negative zero,
        // which must pass the sign test and close the packet.
        send_item(CMD_DISCONNECT, 8'hFF);
        send_word(magic_now);
        send_word(type_now);
        send_word(32'hFFFF_FFFF);
        send_word(32'd1);
        send_word(NEG_ZERO_BITS);
        send_word(32'hFFFF_FFFF);

        // Six phases of random packets under changing register settings, with the
        // reset, all-zero and all-one values among them.
        for (int p = 0; p < 6; p++)
        begin
            if (p != 0)
            begin
                drain_results();
                case (p)
                    1:
                    begin
                        m = '0;
                        t = '0;
                    end
                    2:
                    begin
                        m = '1;
                        t = '1;
                    end
                    4:
                    begin
                        m = MAGIC_RESET;
                        t = TYPE_RESET;
                    end
                    5:
                    begin
                        m = $urandom;
                        t = $urandom_range(0, 1023);
                    end
                    default:
                    begin
                        m = $urandom;
                        t = $urandom;
                    end
                endcase
                magic_now = m;
                type_now  = t;
                apb_access(1'b1, {REG_MAGIC, 2'b00}, m);
                apb_access(1'b1, {REG_TYPE, 2'b00}, t);
                apb_access(1'b0, {REG_MAGIC, 2'b00}, '0);
                apb_access(1'b0, {REG_TYPE, 2'b00}, '0);
            end
            while (items_sent < (p + 1) * 240)
            begin
                send_packet();
            end
        end

        drain_results();
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #4000000;
        $display("status: fail");
        $finish;
    end

endmodule
